/* src/kvmt_pkg.sv */
package kvmt_pkg;

	localparam int DefTableDepth = 16;
	localparam int MaxResults    = 16;
	localparam int CountOutW     = 5;

	typedef enum logic [1:0] {
		REQ_INSERT,
		REQ_REMOVE,
		REQ_SEARCH,
		REQ_QUERY
	} req_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NOT_FOUND,
		ST_FULL
	} stat_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_OK,
		EM_NOT_FOUND,
		EM_FULL,
		EM_SPREAD,
		EM_SEARCH_END
	} emit_t;

	typedef struct packed {
		logic  load;
		logic  issue;
		logic  shift_rd;
		logic  ins;
		logic  dec;
		emit_t emit;
	} kvmt_cmd_t;

	typedef struct packed {
		req_t req;
		logic full;
		logic issued_all;
		logic found;
		logic rd_vld;
		logic shift_more;
	} kvmt_stat_t;

endpackage

/* src/kvmt_datapath.sv */
module kvmt_datapath import kvmt_pkg::*; #(
	parameter int TableDepth = DefTableDepth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kvmt_cmd_t                  cmd,
	output kvmt_stat_t                 st,
	input  logic [1:0]                 req_type,
	input  logic signed [31:0]         key,
	input  logic signed [31:0]         value,
	output logic                       result_strobe,
	output logic [1:0]                 status,
	output logic signed [31:0]         found_value,
	output logic                       last,
	output logic [CountOutW-1:0]       pair_count,
	output logic                       is_empty,
	output logic signed [32:0]         value_spread
);

	localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CW = $clog2(TableDepth + 1);
	localparam int HW = $clog2(MaxResults + 1);

	logic signed [31:0] key_mem [TableDepth];
	logic signed [31:0] val_mem [TableDepth];

	req_t               req_q;
	logic signed [31:0] key_q, val_q;
	logic [CW-1:0]      count_q, ptr_q;
	logic               issued_all_q, found_q, first_q, pend_vld_q;
	logic [HW-1:0]      hits_q;
	logic signed [31:0] min_q, max_q, pend_q;
	logic               rd_vld_s1, rd_shift_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic signed [31:0] rd_key_s1, rd_val_s1;
	logic               out_vld_q;
	stat_t              out_stat_q;
	logic signed [31:0] out_fv_q;
	logic               out_last_q;
	logic [CountOutW-1:0] out_cnt_q;
	logic               out_empty_q;
	logic signed [32:0] out_spread_q;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               key_hit, search_take, rm_hit, mid_emit;
	logic signed [32:0] spread;
	logic               o_fire;
	stat_t              o_stat;
	logic signed [31:0] o_fv;
	logic               o_last;
	logic signed [32:0] o_spread;
	logic [31:0]        count_wide;

	assign rd_en       = cmd.issue | cmd.shift_rd;
	assign rd_addr     = ptr_q[AW-1:0];
	assign key_hit     = rd_vld_s1 && !rd_shift_s1 && (rd_key_s1 == key_q);
	assign search_take = key_hit && (req_q == REQ_SEARCH) && (hits_q != HW'(MaxResults));
	assign rm_hit      = key_hit && (req_q == REQ_REMOVE) && (rd_val_s1 == val_q) && !found_q;
	assign mid_emit    = search_take && pend_vld_q;
	assign spread      = {max_q[31], max_q} - {min_q[31], min_q};
	assign count_wide  = 32'(count_q);

	assign st.req        = req_q;
	assign st.full       = (count_q == CW'(TableDepth));
	assign st.issued_all = issued_all_q;
	assign st.found      = found_q;
	assign st.rd_vld     = rd_vld_s1;
	assign st.shift_more = (ptr_q < count_q);

	// one write port (insert or shift-down), one registered read port
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			key_mem[count_q[AW-1:0]] <= key_q;
			val_mem[count_q[AW-1:0]] <= val_q;
		end else if (rd_vld_s1 && rd_shift_s1) begin
			key_mem[rd_idx_s1 - AW'(1)] <= rd_key_s1;
			val_mem[rd_idx_s1 - AW'(1)] <= rd_val_s1;
		end
		if (rd_en) begin
			rd_key_s1 <= key_mem[rd_addr];
			rd_val_s1 <= val_mem[rd_addr];
			rd_idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ptr_q        <= '0;
			issued_all_q <= 1'b0;
			found_q      <= 1'b0;
			first_q      <= 1'b0;
			pend_vld_q   <= 1'b0;
			hits_q       <= '0;
			rd_vld_s1    <= 1'b0;
			rd_shift_s1  <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			rd_shift_s1 <= cmd.shift_rd;
			out_vld_q   <= o_fire;
			if (cmd.load) begin
				ptr_q        <= count_q - CW'(1);
				issued_all_q <= (count_q == '0);
				found_q      <= 1'b0;
				first_q      <= 1'b1;
				pend_vld_q   <= 1'b0;
				hits_q       <= '0;
			end
			if (cmd.issue) begin
				ptr_q <= ptr_q - CW'(1);
				if (ptr_q == '0)
					issued_all_q <= 1'b1;
			end
			if (cmd.shift_rd)
				ptr_q <= ptr_q + CW'(1);
			// newest match found: shifting starts just above it
			if (rm_hit) begin
				found_q <= 1'b1;
				ptr_q   <= CW'(rd_idx_s1) + CW'(1);
			end
			if (search_take) begin
				pend_vld_q <= 1'b1;
				hits_q     <= hits_q + HW'(1);
			end
			if (rd_vld_s1 && !rd_shift_s1 && req_q == REQ_QUERY)
				first_q <= 1'b0;
			if (cmd.ins)
				count_q <= count_q + CW'(1);
			if (cmd.dec)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_t'(req_type);
			key_q <= key;
			val_q <= value;
		end
		if (search_take)
			pend_q <= rd_val_s1;
		if (rd_vld_s1 && !rd_shift_s1 && req_q == REQ_QUERY) begin
			if (first_q || rd_val_s1 < min_q)
				min_q <= rd_val_s1;
			if (first_q || rd_val_s1 > max_q)
				max_q <= rd_val_s1;
		end
		if (o_fire) begin
			out_stat_q   <= o_stat;
			out_fv_q     <= o_fv;
			out_last_q   <= o_last;
			out_spread_q <= o_spread;
			out_cnt_q    <= count_wide[CountOutW-1:0];
			out_empty_q  <= (count_q == '0);
		end
	end

	always_comb begin
		o_fire   = 1'b1;
		o_stat   = ST_OK;
		o_fv     = '0;
		o_last   = 1'b1;
		o_spread = '0;
		case (cmd.emit)
			EM_OK:        o_stat = ST_OK;
			EM_NOT_FOUND: o_stat = ST_NOT_FOUND;
			EM_FULL:      o_stat = ST_FULL;
			EM_SPREAD:    o_spread = (count_q == '0) ? '1 : spread;
			EM_SEARCH_END: begin
				if (pend_vld_q)
					o_fv = pend_q;
				else
					o_stat = ST_NOT_FOUND;
			end
			default: begin
				// a further, older match pushes out the held one, which cannot be the last
				o_fire = mid_emit;
				o_fv   = pend_q;
				o_last = 1'b0;
			end
		endcase
	end

	assign result_strobe = out_vld_q;
	assign status        = out_stat_q;
	assign found_value   = out_fv_q;
	assign last          = out_last_q;
	assign pair_count    = out_cnt_q;
	assign is_empty      = out_empty_q;
	assign value_spread  = out_spread_q;

endmodule

/* src/kvmt_ctrl.sv */
module kvmt_ctrl import kvmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] req_type,
	input  kvmt_stat_t st,
	output logic       busy,
	output kvmt_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_SHIFT,
		S_FIN
	} state_t;

	state_t state_q;
	emit_t  kind_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.emit     = EM_NONE;
		case (state_q)
			S_IDLE: cmd.load = start;
			S_INS: begin
				if (st.full)
					cmd.emit = EM_FULL;
				else
					cmd.ins = 1'b1;
			end
			S_SCAN: begin
				if (!(st.req == REQ_REMOVE && st.found) && !st.issued_all)
					cmd.issue = 1'b1;
			end
			S_SHIFT: begin
				if (st.shift_more)
					cmd.shift_rd = 1'b1;
				else if (!st.rd_vld)
					cmd.dec = 1'b1;
			end
			S_FIN:   cmd.emit = kind_q;
			default: cmd.emit = EM_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= EM_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= (req_t'(req_type) == REQ_INSERT) ? S_INS : S_SCAN;
				end
				S_INS: begin
					if (st.full) begin
						state_q <= S_IDLE;
					end else begin
						kind_q  <= EM_OK;
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (st.req == REQ_REMOVE && st.found) begin
						state_q <= S_SHIFT;
					end else if (st.issued_all && !st.rd_vld) begin
						state_q <= S_FIN;
						case (st.req)
							REQ_REMOVE: kind_q <= EM_NOT_FOUND;
							REQ_SEARCH: kind_q <= EM_SEARCH_END;
							REQ_QUERY:  kind_q <= EM_SPREAD;
							default:    kind_q <= EM_OK;
						endcase
					end
				end
				S_SHIFT: begin
					// drain the last move before dropping the count
					if (!st.shift_more && !st.rd_vld) begin
						kind_q  <= EM_OK;
						state_q <= S_FIN;
					end
				end
				S_FIN:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/key_value_multimap_table_core.sv */
// channel   direction  handshake                      fields
// request   in         start & !busy accepts          req_type, key, value
// result    out        result_strobe, one cycle each  status, found_value, last,
//                                                     pair_count, is_empty, value_spread
//
// Insert appends the pair above the newest entry, or reports full when the table is full.
// Search and query read one stored entry per cycle through the table's single read port.
// Remove scans newest first to the match, then moves each newer entry down one slot per
// cycle.
// Reset clears the pair count; table entries are undefined and never read until written.
// Results leave on a one-cycle strobe; the receiver cannot stall, so none is held back.
module key_value_multimap_table_core import kvmt_pkg::*; #(
	parameter int TableDepth = DefTableDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic signed [31:0]   key,
	input  logic signed [31:0]   value,
	output logic                 result_strobe,
	output logic [1:0]           status,
	output logic signed [31:0]   found_value,
	output logic                 last,
	output logic [CountOutW-1:0] pair_count,
	output logic                 is_empty,
	output logic signed [32:0]   value_spread
);

	kvmt_cmd_t  cmd;
	kvmt_stat_t st;

	kvmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.st       (st),
		.busy     (busy),
		.cmd      (cmd)
	);

	kvmt_datapath #(
		.TableDepth (TableDepth)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.req_type      (req_type),
		.key           (key),
		.value         (value),
		.result_strobe (result_strobe),
		.status        (status),
		.found_value   (found_value),
		.last          (last),
		.pair_count    (pair_count),
		.is_empty      (is_empty),
		.value_spread  (value_spread)
	);

endmodule
